>>> rtl/dfq_pkg.sv
// dfq_pkg: shared constants and types for the duplicate-rejecting queue
// request codes, status codes and the result word layout
// no dependencies
package dfq_pkg;

    // default number of queue entries
    localparam int DEPTH_DEF = 16;

    // field widths fixed by the interface
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP_TAIL  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CONTAINS  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_AT   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_TAIL = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ERR    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd4;

    // one result word, packed lowest field last
    typedef struct packed {
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [VALUE_W-1:0]  read_value;
    } res_t;

endpackage

>>> rtl/dfq_mem.sv
// dfq_mem: entry store, one write port and one read port
// read data registered; no reset on the contents
// depends on nothing
module dfq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dfq_ctrl.sv
// dfq_ctrl: request sequencer for the duplicate-rejecting queue
// keeps head pointer and count, scans and shifts the entry store word by word
// depends on dfq_pkg; drives the ports of dfq_mem
module dfq_ctrl #(
    parameter int DEPTH = dfq_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request side
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dfq_pkg::REQ_W-1:0]    in_req,
    input  logic [dfq_pkg::VALUE_W-1:0]  in_value,
    input  logic [dfq_pkg::POS_W-1:0]    in_pos,
    // result side
    output logic                         res_valid,
    input  logic                         res_ready,
    output dfq_pkg::res_t                res,
    // entry store
    output logic                         mem_we,
    output logic [IW-1:0]                mem_waddr,
    output logic [dfq_pkg::VALUE_W-1:0]  mem_wdata,
    output logic [IW-1:0]                mem_raddr,
    input  logic [dfq_pkg::VALUE_W-1:0]  mem_rdata
);
    import dfq_pkg::*;

    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [CW-1:0]        pidx_reg, pidx_next;
    logic [VALUE_W-1:0]   rd_val_reg, rd_val_next;
    logic                 found_reg, found_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 issue;
    logic                 hit;
    logic [IW-1:0]        new_head;

    // logical position from the head to a slot of the circular store
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd,
                                           input logic [CW-1:0] i);
        logic [CW:0] sum;
        sum = (CW + 1)'(hd) + (CW + 1)'(i);
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IW-1:0];
    endfunction

    assign issue    = (idx_reg < count_reg);
    assign hit      = pend_reg && (mem_rdata == val_reg);
    assign new_head = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        rd_val_next = rd_val_reg;
        found_next  = found_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = head_reg;
        mem_wdata   = val_reg;
        mem_raddr   = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    req_next    = in_req;
                    val_next    = in_value;
                    idx_next    = '0;
                    rd_val_next = '0;
                    found_next  = 1'b0;
                    status_next = STAT_OK;
                    unique case (in_req)
                        REQ_INSERT, REQ_REMOVE, REQ_CONTAINS: begin
                            state_next = S_SCAN;
                        end
                        REQ_POP_TAIL, REQ_PEEK_TAIL: begin
                            if (count_reg == '0) begin
                                status_next = STAT_ERR;
                                state_next  = S_DONE;
                            end else begin
                                mem_raddr  = phys(head_reg, count_reg - 1'b1);
                                state_next = S_RDWAIT;
                            end
                        end
                        REQ_READ_AT: begin
                            if (COUNT_W'(in_pos) < COUNT_W'(count_reg)) begin
                                mem_raddr  = phys(head_reg, CW'(in_pos));
                                state_next = S_RDWAIT;
                            end else begin
                                status_next = STAT_ERR;
                                state_next  = S_DONE;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // one read issued and one compared per cycle
            S_SCAN: begin
                if (issue) begin
                    mem_raddr = phys(head_reg, idx_reg);
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                if (hit) begin
                    pend_next = 1'b0;
                    if (req_reg == REQ_INSERT) begin
                        status_next = STAT_DUP;
                        state_next  = S_DONE;
                    end else if (req_reg == REQ_CONTAINS) begin
                        found_next = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        found_next = 1'b1;
                        if (pidx_reg + 1'b1 < count_reg) begin
                            idx_next   = pidx_reg + 1'b1;
                            state_next = S_SHIFT;
                        end else begin
                            count_next = count_reg - 1'b1;
                            state_next = S_DONE;
                        end
                    end
                end else if (!issue) begin
                    // every held entry compared, no match
                    state_next = S_DONE;
                    if (req_reg == REQ_INSERT) begin
                        if (count_reg == DEPTH_C) begin
                            status_next = STAT_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = new_head;
                            mem_wdata  = val_reg;
                            head_next  = new_head;
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        status_next = STAT_ABSENT;
                    end
                end
            end

            // close the gap: read entry i+1, write it to i in the following cycle
            S_SHIFT: begin
                if (issue) begin
                    mem_raddr = phys(head_reg, idx_reg);
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg - 1'b1;
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = phys(head_reg, pidx_reg);
                    mem_wdata = mem_rdata;
                end
                if (!issue) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_RDWAIT: begin
                rd_val_next = mem_rdata;
                if (req_reg == REQ_POP_TAIL) begin
                    count_next = count_reg - 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            pend_reg  <= pend_next;
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        rd_val_reg <= rd_val_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.read_value  = rd_val_reg;
    assign res.found       = found_reg;
    assign res.status      = status_reg;
    assign res.entry_count = COUNT_W'(count_reg);

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !res_valid)
        else $error("request taken while a result is pending");

    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken back to back");

    a_count_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + 1'b1) ||
                 (count_reg == $past(count_reg) - 1'b1))
        else $error("count moved by more than one");

    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_SCAN) || (state_reg == S_SHIFT))
        else $error("store written outside insert or shift");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("pending result changed");

endmodule

>>> rtl/dedup_fifo_queue_top.sv
// dedup_fifo_queue_top: ordered queue of unique 32-bit values, stream ports
// instantiates dfq_ctrl and dfq_mem and holds the result output register
// depends on dfq_pkg, dfq_ctrl and dfq_mem
//
// Requests arrive on the s_ channel, one result word per request leaves on
// the m_ channel in request order. s_tuser carries the request kind
// (insert at head, remove tail, remove value, contains, read at position,
// peek tail), s_tdata the value and position.
// Entries live in a circular single-port-read memory; the head pointer moves
// on insert so no data is shifted there.
// Remove tail, peek tail and read-at fetch the entry through the read port
// before the result is ready; unused kinds and failures on an empty queue or
// a bad position go straight to the result. Insert, contains and remove value
// compare one entry per cycle through the read port and stop at the first
// match; a remove that hits entry k then moves the older entries up one by
// one to close the gap.
// One request at a time; the next is taken once its result sits in the output register.
// Reset empties the queue at once; memory contents need no clearing.
// While m_tready is low one result waits in the output register and the
// sequencer holds the next finished result, so nothing is lost.
module dedup_fifo_queue_top #(
    parameter int DEPTH = dfq_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[39:32]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], found[32], status[35:33],
                                   // entry_count[44:36], zero[47:45]
);
    import dfq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                res_valid;
    logic                res_ready;
    res_t                res;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [VALUE_W-1:0]  mem_wdata;
    logic [IW-1:0]       mem_raddr;
    logic [VALUE_W-1:0]  mem_rdata;

    logic                out_valid_reg;
    res_t                out_data_reg;

    dfq_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_value  (s_tdata[31:0]),
        .in_pos    (s_tdata[39:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    dfq_mem #(
        .DEPTH (DEPTH),
        .AW    (IW),
        .DW    (VALUE_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register, refilled in the cycle its word is taken
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

endmodule
